FILE: rtl/lepe_pkg.sv
// Shared constants, types and configuration codes of the line edge position estimator.
// Used by every module of the block; depends on nothing else.
package lepe_pkg;

  localparam int MaxSensors = 32;
  localparam int IdxW       = $clog2(MaxSensors);
  localparam int CntW       = $clog2(MaxSensors + 1);
  localparam int DarkW      = 13;
  localparam int PitchW     = 8;
  localparam int MaxRepW    = 2;
  localparam int PosW       = CntW + 13;
  localparam int ProdW      = PosW + PitchW + 1;
  localparam int QueueDepth = 2;
  localparam int QPtrW      = $clog2(QueueDepth);
  localparam int QCntW      = $clog2(QueueDepth + 1);

  localparam logic [DarkW-1:0] OneQ12 = 13'd4096;

  typedef enum logic [1:0] {
    CFG_PITCH     = 2'd0,
    CFG_FULL_DARK = 2'd1,
    CFG_PART_DARK = 2'd2,
    CFG_MAX_REP   = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [PitchW-1:0]  pitch;
    logic [DarkW-1:0]   full_lvl;
    logic [DarkW-1:0]   part_lvl;
    logic [MaxRepW-1:0] max_rep;
  } cfg_t;

  // Everything the position math needs from one frame.
  typedef struct packed {
    logic [CntW-1:0]  n;
    logic             found_p;
    logic             found_f;
    logic [IdxW-1:0]  fp;
    logic [IdxW-1:0]  ff;
    logic [IdxW-1:0]  lp;
    logic [IdxW-1:0]  lf;
    logic [DarkW-1:0] dark_fp;
    logic [DarkW-1:0] dark_fp_next;
    logic [DarkW-1:0] dark_lp;
    logic [DarkW-1:0] dark_lp_prev;
  } job_t;

endpackage

FILE: rtl/lepe_front.sv
// Front end: takes brightness samples, tracks first/last non-white and black sensors,
// and hands one frame summary to the job queue at the end of each frame. Uses lepe_pkg.
module lepe_front
  import lepe_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  cfg_t             cfg,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [DarkW-1:0] brightness,
  input  logic             last_sample,
  input  logic             queue_full,
  output logic             job_push,
  output job_t             job
);

  logic [CntW-1:0]  count_r, count_nxt, count_upd;
  logic             found_p_r, found_p_nxt, found_p_upd;
  logic             found_f_r, found_f_nxt, found_f_upd;
  logic             cap_next_r, cap_next_nxt, cap_next_upd;
  logic [IdxW-1:0]  fp_r, fp_nxt, fp_upd;
  logic [IdxW-1:0]  ff_r, ff_nxt, ff_upd;
  logic [IdxW-1:0]  lp_r, lp_nxt, lp_upd;
  logic [IdxW-1:0]  lf_r, lf_nxt, lf_upd;
  logic [DarkW-1:0] dfp_r, dfp_upd;
  logic [DarkW-1:0] dfpn_r, dfpn_upd;
  logic [DarkW-1:0] dlp_r, dlp_upd;
  logic [DarkW-1:0] dlpm1_r, dlpm1_upd;
  logic [DarkW-1:0] prev_d_r, prev_d_upd;

  logic             accept;
  logic             store;
  logic [IdxW-1:0]  idx;
  logic [DarkW-1:0] b_sat;
  logic [DarkW-1:0] dark;
  logic             hit_p;
  logic             hit_f;

  assign in_ready = !queue_full;
  assign accept   = in_valid && in_ready;
  assign store    = count_r < CntW'(MaxSensors);
  assign idx      = count_r[IdxW-1:0];
  assign b_sat    = (brightness > OneQ12) ? OneQ12 : brightness;
  assign dark     = OneQ12 - b_sat;
  assign hit_p    = dark > cfg.part_lvl;
  assign hit_f    = dark >= cfg.full_lvl;

  always_comb begin
    count_upd    = count_r;
    found_p_upd  = found_p_r;
    found_f_upd  = found_f_r;
    cap_next_upd = cap_next_r;
    fp_upd       = fp_r;
    ff_upd       = ff_r;
    lp_upd       = lp_r;
    lf_upd       = lf_r;
    dfp_upd      = dfp_r;
    dfpn_upd     = dfpn_r;
    dlp_upd      = dlp_r;
    dlpm1_upd    = dlpm1_r;
    prev_d_upd   = prev_d_r;
    if (accept && store) begin
      // The sensor right after the first non-white one is needed by the left scan.
      if (cap_next_r) begin
        dfpn_upd     = dark;
        cap_next_upd = 1'b0;
      end
      if (hit_p) begin
        if (!found_p_r) begin
          fp_upd       = idx;
          dfp_upd      = dark;
          dfpn_upd     = '0;
          cap_next_upd = 1'b1;
        end
        lp_upd      = idx;
        dlp_upd     = dark;
        dlpm1_upd   = (idx != '0) ? prev_d_r : '0;
        found_p_upd = 1'b1;
      end
      if (hit_f) begin
        if (!found_f_r) begin
          ff_upd = idx;
        end
        lf_upd      = idx;
        found_f_upd = 1'b1;
      end
      prev_d_upd = dark;
      count_upd  = count_r + CntW'(1);
    end
  end

  assign job_push = accept && last_sample;

  always_comb begin
    job.n            = count_upd;
    job.found_p      = found_p_upd;
    job.found_f      = found_f_upd;
    job.fp           = fp_upd;
    job.ff           = ff_upd;
    job.lp           = lp_upd;
    job.lf           = lf_upd;
    job.dark_fp      = dfp_upd;
    job.dark_fp_next = dfpn_upd;
    job.dark_lp      = dlp_upd;
    job.dark_lp_prev = dlpm1_upd;
  end

  always_comb begin
    if (job_push) begin
      count_nxt    = '0;
      found_p_nxt  = 1'b0;
      found_f_nxt  = 1'b0;
      cap_next_nxt = 1'b0;
      fp_nxt       = '0;
      ff_nxt       = '0;
      lp_nxt       = '0;
      lf_nxt       = '0;
    end else begin
      count_nxt    = count_upd;
      found_p_nxt  = found_p_upd;
      found_f_nxt  = found_f_upd;
      cap_next_nxt = cap_next_upd;
      fp_nxt       = fp_upd;
      ff_nxt       = ff_upd;
      lp_nxt       = lp_upd;
      lf_nxt       = lf_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r    <= '0;
      found_p_r  <= 1'b0;
      found_f_r  <= 1'b0;
      cap_next_r <= 1'b0;
      fp_r       <= '0;
      ff_r       <= '0;
      lp_r       <= '0;
      lf_r       <= '0;
    end else begin
      count_r    <= count_nxt;
      found_p_r  <= found_p_nxt;
      found_f_r  <= found_f_nxt;
      cap_next_r <= cap_next_nxt;
      fp_r       <= fp_nxt;
      ff_r       <= ff_nxt;
      lp_r       <= lp_nxt;
      lf_r       <= lf_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dfp_r    <= dfp_upd;
    dfpn_r   <= dfpn_upd;
    dlp_r    <= dlp_upd;
    dlpm1_r  <= dlpm1_upd;
    prev_d_r <= prev_d_upd;
  end

`ifndef SYNTHESIS
  a_cap_needs_partial: assert property (@(posedge clk) disable iff (!rst_n)
    cap_next_r |-> found_p_r)
    else $error("front: waiting for next sample without a first non-white sensor");
`endif

endmodule

FILE: rtl/lepe_queue.sv
// Short job queue between the front end and the back end of the edge estimator.
// Holds whole frame summaries; uses lepe_pkg.
module lepe_queue
  import lepe_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output logic empty,
  output job_t head
);

  job_t             slots_r [QueueDepth];
  logic [QPtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCntW-1:0] count_r, count_nxt;

  assign full  = count_r == QCntW'(QueueDepth);
  assign empty = count_r == '0;
  assign head  = slots_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPtrW'(QueueDepth - 1)) ? '0 : wr_ptr_r + QPtrW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPtrW'(QueueDepth - 1)) ? '0 : rd_ptr_r + QPtrW'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + QCntW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - QCntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_job;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (push && full) |-> pop)
    else $error("queue: push while full");
`endif

endmodule

FILE: rtl/lepe_back.sv
// Back end: turns a frame summary into its left and/or right edge position in mm
// (case selection, centering, pitch scaling, rounding, saturation). Uses lepe_pkg.
module lepe_back
  import lepe_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  cfg_t             cfg,
  input  logic             queue_empty,
  input  job_t             head,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [PitchW-1:0] out_pos,
  output logic             out_side,
  output logic             out_last
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_POS,
    S_REL,
    S_MUL,
    S_RND,
    S_WAIT
  } state_t;

  state_t                   state_r;
  job_t                     job_r;
  logic                     side_r;
  logic                     emit_r_r;
  logic signed [PosW-1:0]   pos_r;
  logic signed [PosW-1:0]   rel_r;
  logic signed [ProdW-1:0]  prod_r;
  logic                     valid_r;
  logic [PitchW-1:0]        pos_mm_r;
  logic                     side_out_r;
  logic                     last_r;

  logic [MaxRepW-1:0]       limit;
  logic                     emit_l;
  logic                     emit_r;
  logic [CntW-1:0]          fnw_full;
  logic [CntW-1:0]          fb_full;
  logic [IdxW-1:0]          fnw;
  logic [IdxW-1:0]          fb;
  logic [CntW-1:0]          fnw1;
  logic [DarkW-1:0]         dk;
  logic [DarkW-1:0]         nx;
  logic signed [PosW-1:0]   pos_calc;
  logic [CntW-1:0]          n_m1;
  logic signed [PosW-1:0]   half;
  logic signed [PosW-1:0]   rel_calc;
  logic [ProdW-1:0]         mag;
  logic [ProdW-1:0]         mag_rnd;
  logic [ProdW-13:0]        q;
  logic [PitchW-1:0]        q_sat;

  function automatic logic signed [PosW-1:0] idx_q12(input logic [CntW-1:0] v);
    idx_q12 = {1'b0, v, 12'b0};
  endfunction

  function automatic logic signed [PosW-1:0] dark_ext(input logic [DarkW-1:0] v);
    dark_ext = {{(PosW - DarkW){1'b0}}, v};
  endfunction

  // A value of 3 in max_reported behaves as 2.
  assign limit  = (cfg.max_rep > MaxRepW'(2)) ? MaxRepW'(2) : cfg.max_rep;
  assign emit_l = head.found_p && (limit != '0);
  assign emit_r = head.found_p && (emit_l ? (limit == MaxRepW'(2)) : (limit != '0));
  assign pop    = (state_r == S_IDLE) && !queue_empty;

  // The right scan runs on the mirrored array.
  assign fnw_full = job_r.n - CntW'(1) - {1'b0, job_r.lp};
  assign fb_full  = job_r.n - CntW'(1) - {1'b0, job_r.lf};

  always_comb begin
    if (side_r) begin
      fnw = fnw_full[IdxW-1:0];
      fb  = fb_full[IdxW-1:0];
      dk  = job_r.dark_lp;
      nx  = job_r.dark_lp_prev;
    end else begin
      fnw = job_r.fp;
      fb  = job_r.ff;
      dk  = job_r.dark_fp;
      nx  = job_r.dark_fp_next;
    end
  end

  assign fnw1 = {1'b0, fnw} + CntW'(1);

  always_comb begin
    if (job_r.found_f) begin
      if (({1'b0, fb} == fnw1) || ((fb != '0) && (fb != fnw))) begin
        pos_calc = idx_q12({1'b0, fb}) - dark_ext(dk);
      end else if (fb != '0) begin
        pos_calc = idx_q12({1'b0, fb});
      end else begin
        pos_calc = '0;
      end
    end else begin
      if (nx != '0) begin
        pos_calc = idx_q12(fnw1) - dark_ext(dk);
      end else begin
        pos_calc = idx_q12({1'b0, fnw});
      end
    end
  end

  assign n_m1     = job_r.n - CntW'(1);
  assign half     = {2'b0, n_m1, 11'b0};
  assign rel_calc = side_r ? (half - pos_r) : (pos_r - half);

  assign mag     = prod_r[ProdW-1] ? ProdW'(-prod_r) : ProdW'(prod_r);
  assign mag_rnd = mag + ProdW'(2048);
  assign q       = mag_rnd[ProdW-1:12];

  always_comb begin
    if (prod_r[ProdW-1]) begin
      q_sat = (q > (ProdW-12)'(128)) ? 8'h80 : PitchW'(-q[PitchW-1:0]);
    end else begin
      q_sat = (q > (ProdW-12)'(127)) ? 8'h7F : q[PitchW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      valid_r  <= 1'b0;
      side_r   <= 1'b0;
      emit_r_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (!queue_empty) begin
            job_r    <= head;
            side_r   <= !emit_l;
            emit_r_r <= emit_r;
            if (emit_l || emit_r) begin
              state_r <= S_POS;
            end
          end
        end
        S_POS: begin
          pos_r   <= pos_calc;
          state_r <= S_REL;
        end
        S_REL: begin
          rel_r   <= rel_calc;
          state_r <= S_MUL;
        end
        S_MUL: begin
          // Both operands are widened first so the product keeps every bit.
          prod_r  <= ProdW'(rel_r) * ProdW'($signed({1'b0, cfg.pitch}));
          state_r <= S_RND;
        end
        S_RND: begin
          pos_mm_r   <= q_sat;
          side_out_r <= side_r;
          last_r     <= side_r || !emit_r_r;
          valid_r    <= 1'b1;
          state_r    <= S_WAIT;
        end
        S_WAIT: begin
          if (out_ready) begin
            valid_r <= 1'b0;
            if (!side_r && emit_r_r) begin
              side_r  <= 1'b1;
              state_r <= S_POS;
            end else begin
              state_r <= S_IDLE;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid = valid_r;
  assign out_pos   = pos_mm_r;
  assign out_side  = side_out_r;
  assign out_last  = last_r;

`ifndef SYNTHESIS
  a_valid_only_waiting: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |-> (state_r == S_WAIT))
    else $error("back: result shown outside the wait state");
  a_right_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && side_out_r) |-> last_r)
    else $error("back: right edge result not marked last");
  a_pop_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> (state_r == S_POS || state_r == S_IDLE))
    else $error("back: unexpected state after taking a job");
`endif

endmodule

FILE: rtl/line_edge_position_estimator.sv
// Top level of the line edge position estimator: configuration registers, front end,
// job queue and back end. Depends on lepe_pkg, lepe_front, lepe_queue and lepe_back.
//
// Usage: one frame of brightness samples (0..4096, 4096 = white) enters on in_*, one
// request per sensor, with in_tlast on the final sensor. At most 32 sensors of a frame
// are used; further samples only count toward the frame end. After the last sample the
// block emits the left edge and then the right edge on out_*, each only if found, and
// at most max_reported of them; out_tuser is the side, out_tlast marks the last result.
// Throughput: one sample per cycle while the job queue has room. Each result passes the
// back end's position, centering, multiply and rounding steps in turn; the second starts
// only once the first is accepted. The queue holds two frame summaries, so sampling
// goes on while results wait; in_tready drops only when both entries are taken. A stalled
// out_tready holds the result steady. Registers are written on cfg_* (always ready) by
// the user only while no frame is in flight; the block does not enforce this. Reset
// (rst_n low, synchronous) clears the queue, the frame tracking and the output, and
// loads pitch 10, full level 3686, partial level 410 and two results per frame.
module line_edge_position_estimator
  import lepe_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [12:0] brightness, [15:13] zero
  input  logic        in_tlast,   // last_sample
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] position_mm (signed)
  output logic        out_tuser,  // [0] edge_side
  output logic        out_tlast,  // last_result
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [12:0] cfg_data
);

  cfg_t cfg_r;
  logic queue_full;
  logic queue_empty;
  logic job_push;
  logic job_pop;
  job_t push_job;
  job_t head_job;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pitch    <= PitchW'(10);
      cfg_r.full_lvl <= DarkW'(3686);
      cfg_r.part_lvl <= DarkW'(410);
      cfg_r.max_rep  <= MaxRepW'(2);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_PITCH:     cfg_r.pitch    <= cfg_data[PitchW-1:0];
        CFG_FULL_DARK: cfg_r.full_lvl <= cfg_data;
        CFG_PART_DARK: cfg_r.part_lvl <= cfg_data;
        CFG_MAX_REP:   cfg_r.max_rep  <= cfg_data[MaxRepW-1:0];
        default:       cfg_r          <= cfg_r;
      endcase
    end
  end

  lepe_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .brightness  (in_tdata[DarkW-1:0]),
    .last_sample (in_tlast),
    .queue_full  (queue_full),
    .job_push    (job_push),
    .job         (push_job)
  );

  lepe_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (job_push),
    .push_job (push_job),
    .full     (queue_full),
    .pop      (job_pop),
    .empty    (queue_empty),
    .head     (head_job)
  );

  lepe_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .queue_empty (queue_empty),
    .head        (head_job),
    .pop         (job_pop),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_pos     (out_tdata),
    .out_side    (out_tuser),
    .out_last    (out_tlast)
  );

endmodule

FILE: dv/lepe_edge_checker.sv
// Scoreboard for the line edge position estimator: tracks register writes and samples,
// predicts the edge results of each frame and compares them with the result stream.
// Depends on lepe_pkg for the register codes and the block's widths.
module lepe_edge_checker
  import lepe_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [15:0] in_tdata,   // [12:0] brightness, [15:13] zero
  input  logic        in_tlast,   // last_sample
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [7:0]  out_tdata,  // [7:0] position_mm (signed)
  input  logic        out_tuser,  // [0] edge_side
  input  logic        out_tlast,  // last_result
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [12:0] cfg_data,
  output int          mismatch_count,
  output int          edges_pending
);

  localparam longint Q12One  = 4096;
  localparam longint Q12Half = 2048;

  typedef struct packed {
    logic signed [7:0] position_mm;
    logic              edge_side;
    logic              last_result;
  } edge_result_t;

  edge_result_t expected_edges[$];

  logic [PitchW-1:0]  pitch;
  logic [DarkW-1:0]   full_lvl;
  logic [DarkW-1:0]   part_lvl;
  logic [MaxRepW-1:0] max_rep;

  logic [DarkW-1:0] darkness [MaxSensors];
  int unsigned      n_samples;
  int unsigned      first_part, first_full, last_part, last_full;
  logic [3:0]       found;  // left partial, left full, right partial, right full

  initial mismatch_count = 0;
  initial edges_pending = 0;

  task automatic report_mismatch(input string msg);
    $display("%0t: mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  // Darkness seen at a scan position; the right scan walks the frame backwards.
  function automatic longint dark_of(input int unsigned scan_idx, input bit right,
                                     input int unsigned n);
    int unsigned idx;
    idx = right ? n - 1 - scan_idx : scan_idx;
    if (idx >= MaxSensors) return 0;
    return longint'(darkness[idx]);
  endfunction

  // Edge position in Q12 sensor units along one scan direction.
  function automatic bit find_edge(input bit right, input int unsigned n,
                                   input bit have_part, input bit have_full,
                                   input int unsigned fnw, input int unsigned fb,
                                   output longint pos);
    longint next_dark;
    pos = 0;
    if (have_part && have_full) begin
      if (fb == fnw + 1 || (fb > 0 && fb != fnw))
        pos = longint'(fb) * Q12One - dark_of(fnw, right, n);
      else if (fb > 0)
        pos = longint'(fb) * Q12One;
      return 1'b1;
    end
    if (have_part) begin
      next_dark = (fnw + 1 < n) ? dark_of(fnw + 1, right, n) : 0;
      if (next_dark > 0)
        pos = longint'(fnw + 1) * Q12One - dark_of(fnw, right, n);
      else if (fnw > 0)
        pos = longint'(fnw) * Q12One;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Centre on the array, scale by pitch, round half away from zero, saturate.
  function automatic logic signed [7:0] scale_to_mm(input longint pos, input bit right,
                                                    input int unsigned n);
    longint rel, v, mag, q;
    rel = pos - longint'(n - 1) * Q12Half;
    if (right) rel = -rel;
    v = rel * longint'(pitch);
    mag = (v < 0) ? -v : v;
    q = (mag + Q12Half) / Q12One;
    if (v < 0) q = -q;
    if (q > 127) q = 127;
    if (q < -128) q = -128;
    return q[7:0];
  endfunction

  task automatic clear_frame();
    n_samples = 0;
    first_part = 0;
    first_full = 0;
    last_part = 0;
    last_full = 0;
    found = 4'b0000;
  endtask

  task automatic take_sample(input logic [DarkW-1:0] brightness, input logic last);
    logic [DarkW-1:0] b, d;
    int unsigned      n, limit;
    longint           pos;
    edge_result_t     frame_edges[$];
    edge_result_t     r;
    b = (brightness > OneQ12) ? OneQ12 : brightness;
    if (n_samples < MaxSensors) begin
      d = OneQ12 - b;
      darkness[n_samples] = d;
      if (d > part_lvl) begin
        if (!found[0]) first_part = n_samples;
        last_part = n_samples;
        found = found | 4'b0101;
      end
      if (d >= full_lvl) begin
        if (!found[1]) first_full = n_samples;
        last_full = n_samples;
        found = found | 4'b1010;
      end
      n_samples++;
    end
    if (!last) return;

    n = n_samples;
    limit = (max_rep > 2) ? 2 : max_rep;
    if (find_edge(1'b0, n, found[0], found[1], first_part, first_full, pos) &&
        frame_edges.size() < limit) begin
      r.position_mm = scale_to_mm(pos, 1'b0, n);
      r.edge_side = 1'b0;
      r.last_result = 1'b0;
      frame_edges.push_back(r);
    end
    if (find_edge(1'b1, n, found[2], found[3], n - 1 - last_part, n - 1 - last_full, pos) &&
        frame_edges.size() < limit) begin
      r.position_mm = scale_to_mm(pos, 1'b1, n);
      r.edge_side = 1'b1;
      r.last_result = 1'b0;
      frame_edges.push_back(r);
    end
    if (frame_edges.size() > 0) frame_edges[frame_edges.size() - 1].last_result = 1'b1;
    foreach (frame_edges[k]) expected_edges.push_back(frame_edges[k]);
    clear_frame();
  endtask

  task automatic check_result();
    edge_result_t exp_r;
    if (expected_edges.size() == 0) begin
      report_mismatch($sformatf("result %0d side %0b with no result expected",
                                $signed(out_tdata), out_tuser));
      return;
    end
    exp_r = expected_edges.pop_front();
    if (out_tdata !== exp_r.position_mm)
      report_mismatch($sformatf("position_mm %0d, expected %0d",
                                $signed(out_tdata), exp_r.position_mm));
    if (out_tuser !== exp_r.edge_side)
      report_mismatch($sformatf("edge_side %0b, expected %0b", out_tuser, exp_r.edge_side));
    if (out_tlast !== exp_r.last_result)
      report_mismatch($sformatf("last_result %0b, expected %0b",
                                out_tlast, exp_r.last_result));
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      pitch = 8'd10;
      full_lvl = 13'd3686;
      part_lvl = 13'd410;
      max_rep = 2'd2;
      clear_frame();
      expected_edges.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_idx_t'(cfg_index))
          CFG_PITCH:     pitch = cfg_data[PitchW-1:0];
          CFG_FULL_DARK: full_lvl = cfg_data;
          CFG_PART_DARK: part_lvl = cfg_data;
          CFG_MAX_REP:   max_rep = cfg_data[MaxRepW-1:0];
          default: ;
        endcase
      end
      // Results are checked first: a result never stems from a sample taken at the same edge.
      if (out_tvalid && out_tready) check_result();
      if (in_tvalid && in_tready) take_sample(in_tdata[DarkW-1:0], in_tlast);
    end
    edges_pending <= expected_edges.size();
  end

endmodule

FILE: dv/line_edge_position_estimator_test.sv
// Top of the line edge position estimator testbench: clock, reset, frame and register
// stimulus, result-side back-pressure and the verdict. Depends on lepe_pkg, the block
// and lepe_edge_checker.
module line_edge_position_estimator_test;
  import lepe_pkg::*;

  localparam int SettleCycles = 40;
  localparam int HoldCycles   = 300;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;
  logic        out_tuser;
  logic        out_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [12:0] cfg_data = '0;

  int mismatch_count;
  int edges_pending;

  bit in_idle_en = 1'b1;
  bit out_idle_en = 1'b1;
  bit hold_req = 1'b0;
  int samples_sent = 0;
  int cur_full = 3686;
  int cur_part = 410;

  line_edge_position_estimator u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  lepe_edge_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tlast      (in_tlast),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .out_tuser     (out_tuser),
    .out_tlast     (out_tlast),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .mismatch_count(mismatch_count),
    .edges_pending (edges_pending)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("line_edge_position_estimator test failed");
    $finish;
  end

  // Result side: random stalls, or one long hold-off while the queue fills up.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        out_tready <= !out_idle_en || ($urandom_range(99) >= 31);
      end
    end
  end

  task automatic send_sample(input logic [12:0] brightness, input logic last);
    while (in_idle_en && $urandom_range(99) < 31) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {3'b000, brightness};
    in_tlast <= last;
    do @(posedge clk); while (!in_tready);
    samples_sent++;
  endtask

  // Waits until every predicted result has come, then lets frames without results finish.
  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (edges_pending != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic load_config(input int pitch, input int full_lvl, input int part_lvl,
                             input int max_rep);
    cfg_idx_t idx;
    idx = CFG_PITCH;
    for (int i = 0; i < 4; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx;
      case (idx)
        CFG_PITCH:     cfg_data <= 13'(pitch);
        CFG_FULL_DARK: cfg_data <= 13'(full_lvl);
        CFG_PART_DARK: cfg_data <= 13'(part_lvl);
        default:       cfg_data <= 13'(max_rep);
      endcase
      do @(posedge clk); while (!cfg_ready);
      idx = idx.next();
    end
    cfg_valid <= 1'b0;
    cur_full = full_lvl;
    cur_part = part_lvl;
  endtask

  // Mostly a white line background with one dark stripe and soft borders; some frames are
  // noise, threshold-edge values or all white. A few run past the sensor count.
  task automatic send_random_frame();
    int r, len, kind, lo, hi, b;
    r = $urandom_range(99);
    len = (r < 4) ? $urandom_range(40, 33) : (r < 15) ? $urandom_range(7, 1)
                                                      : $urandom_range(32, 8);
    kind = $urandom_range(9);
    lo = $urandom_range(len - 1);
    hi = lo + $urandom_range(5);
    for (int i = 0; i < len; i++) begin
      if (kind <= 6) begin
        if (i >= lo && i <= hi) b = $urandom_range(500);
        else if (i == lo - 1 || i == hi + 1) b = $urandom_range(4096);
        else b = 4096 - $urandom_range(350);
        if ($urandom_range(19) == 0) b = $urandom_range(8191, 4097);
      end else if (kind == 7) begin
        b = $urandom_range(8191);
      end else if (kind == 8) begin
        case ($urandom_range(4))
          0: b = 0;
          1: b = 4096;
          2: b = 8191;
          3: b = 4096 - cur_full + $urandom_range(2) - 1;
          default: b = 4096 - cur_part + $urandom_range(2) - 1;
        endcase
      end else begin
        b = 4096 + (($urandom_range(3) == 0) ? $urandom_range(200) : 0);
      end
      if (b < 0) b = 0;
      if (b > 8191) b = 8191;
      send_sample(13'(b), i == len - 1);
    end
  endtask

  task automatic run_phase(input int pitch, input int full_lvl, input int part_lvl,
                           input int max_rep, input int n_items);
    int stop_at;
    load_config(pitch, full_lvl, part_lvl, max_rep);
    stop_at = samples_sent + n_items;
    while (samples_sent < stop_at) begin
      send_random_frame();
      if ($urandom_range(49) == 0) drain_results();
    end
    drain_results();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed frames on the reset settings.
    send_sample(13'd0, 1'b1);                   // single black sensor at index 0
    send_sample(13'd4096, 1'b1);                // single white sensor: no edge
    send_sample(13'd8191, 1'b0);                // brightness above full scale
    send_sample(13'd2048, 1'b0);
    send_sample(13'd0, 1'b1);                   // black right after non-white
    send_sample(13'd4096, 1'b0);
    send_sample(13'd3000, 1'b0);                // non-white only, white neighbor
    send_sample(13'd4096, 1'b0);
    send_sample(13'd4096, 1'b1);
    send_sample(13'd3000, 1'b0);                // non-white only at index 0
    send_sample(13'd4096, 1'b1);
    send_sample(13'd4096, 1'b0);
    send_sample(13'd3000, 1'b0);                // non-white only, grey neighbor
    send_sample(13'd3500, 1'b0);
    send_sample(13'd4096, 1'b1);
    send_sample(13'd0, 1'b0);                   // black at index 0 and 1; left scan starts on black
    send_sample(13'd0, 1'b0);
    send_sample(13'd4096, 1'b1);
    send_sample(13'd2000, 1'b0);                // black two sensors after non-white
    send_sample(13'd4096, 1'b0);
    send_sample(13'd0, 1'b1);
    drain_results();

    run_phase(10, 3686, 410, 2, 200);
    run_phase(255, 4096, 0, 3, 150);
    run_phase(0, 0, 4096, 1, 100);
    run_phase(1, 4096, 4096, 0, 60);
    run_phase(255, 100, 4000, 2, 100);          // levels in the wrong order

    // Long result hold-off while frames keep coming, so the block stalls its input.
    hold_req = 1'b1;
    run_phase(37, 3000, 800, 2, 150);

    in_idle_en = 1'b0;
    out_idle_en = 1'b0;
    run_phase(128, 3686, 410, 2, 200);
    in_idle_en = 1'b1;
    out_idle_en = 1'b1;

    repeat (3) begin
      run_phase($urandom_range(255), $urandom_range(4096), $urandom_range(4096),
                $urandom_range(3), 100);
    end

    if (mismatch_count == 0 && edges_pending == 0) begin
      $display("line_edge_position_estimator test passed");
    end else begin
      $display("line_edge_position_estimator test failed");
    end
    $finish;
  end

endmodule
